### src/rcdad_pkg.sv
// Shared types and helpers for the run-coded DPCM audio decoder.
package rcdad_pkg;

    localparam int unsigned SampleW = 8;
    localparam int unsigned PcmW    = 16;
    localparam int unsigned RunW    = 6;
    localparam int unsigned PendW   = 7;

    localparam logic [SampleW-1:0] PcmOffset = 8'h40;
    localparam logic [1:0]         CtlDelta  = 2'b10;
    localparam logic [1:0]         CtlRepeat = 2'b11;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       stream_start;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] pcm_sample;
        logic               run_last;
    } t_out_item;

    // controller -> datapath
    typedef struct packed {
        logic take_item;
        logic emit_delta2;
        logic emit_repeat;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
        logic to_delta2;
        logic to_repeat;
        logic rep_last;
    } t_dp_sts;

    // (s - 64) * 256, low 16 bits
    function automatic logic [PcmW-1:0] pcm_of(input logic [SampleW-1:0] s);
        logic [SampleW-1:0] d;
        d = s - PcmOffset;
        return {d, 8'h00};
    endfunction

    function automatic logic [SampleW-1:0] sext_nib(input logic [3:0] n);
        return {{4{n[3]}}, n};
    endfunction

endpackage

### src/rcdad_ctrl.sv
// Controller state machine for the run-coded DPCM audio decoder.
module rcdad_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  rcdad_pkg::t_dp_sts i_sts,
    output rcdad_pkg::t_dp_cmd o_cmd
);
    import rcdad_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_DELTA2 = 3'b010,
        ST_REPEAT = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   take;

    assign o_in_ready = (r_state == ST_IDLE) && i_sts.out_free;
    assign take       = o_in_ready && i_in_valid;

    always_comb begin
        n_state           = r_state;
        o_cmd.take_item   = 1'b0;
        o_cmd.emit_delta2 = 1'b0;
        o_cmd.emit_repeat = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (take) begin
                    o_cmd.take_item = 1'b1;
                    if (i_sts.to_delta2) begin
                        n_state = ST_DELTA2;
                    end else if (i_sts.to_repeat) begin
                        n_state = ST_REPEAT;
                    end
                end
            end
            ST_DELTA2: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_delta2 = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_REPEAT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_repeat = 1'b1;
                    if (i_sts.rep_last) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### src/rcdad_dp.sv
// Datapath: sample state, delta count, run counter and output register.
module rcdad_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rcdad_pkg::t_in_item  i_in_data,
    input  rcdad_pkg::t_dp_cmd   i_cmd,
    output rcdad_pkg::t_dp_sts   o_sts,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rcdad_pkg::t_out_item o_out_data
);
    import rcdad_pkg::*;

    logic [SampleW-1:0] r_sample, n_sample;
    logic [PendW-1:0]   r_pending, n_pending;
    logic [RunW-1:0]    r_run, n_run;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [7:0]         b;
    logic               pend_nz;
    logic [SampleW-1:0] s1, s2;

    assign b       = i_in_data.code_byte;
    assign pend_nz = (r_pending != '0);
    assign s1      = r_sample + sext_nib(b[7:4]);
    assign s2      = s1 + sext_nib(b[3:0]);

    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.to_delta2 = !i_in_data.stream_start && pend_nz;
    assign o_sts.to_repeat = !i_in_data.stream_start && !pend_nz
                             && (b[7:6] == CtlRepeat) && (b[5:0] != '0);
    assign o_sts.rep_last  = (r_run == RunW'(1));

    always_comb begin
        n_sample    = r_sample;
        n_pending   = r_pending;
        n_run       = r_run;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;

        if (i_cmd.take_item) begin
            if (i_in_data.stream_start) begin
                n_sample    = b;
                n_pending   = '0;
                n_out       = '{pcm_sample: {b, 8'h00}, run_last: 1'b1};
                n_out_valid = 1'b1;
            end else if (pend_nz) begin
                // first of two samples now, second from the DELTA2 state
                n_sample    = s2;
                n_pending   = r_pending - PendW'(1);
                n_out       = '{pcm_sample: pcm_of(s1), run_last: 1'b0};
                n_out_valid = 1'b1;
            end else if (!b[7]) begin
                n_sample    = b;
                n_out       = '{pcm_sample: pcm_of(b), run_last: 1'b1};
                n_out_valid = 1'b1;
            end else if (b[7:6] == CtlDelta) begin
                n_pending = PendW'(b[5:0]) + PendW'(1);
            end else begin
                // run of low6+1: first sample now, rest counted down
                n_run       = b[5:0];
                n_out       = '{pcm_sample: pcm_of(r_sample),
                                run_last: (b[5:0] == '0)};
                n_out_valid = 1'b1;
            end
        end

        if (i_cmd.emit_delta2) begin
            n_out       = '{pcm_sample: pcm_of(r_sample), run_last: 1'b1};
            n_out_valid = 1'b1;
        end

        if (i_cmd.emit_repeat) begin
            n_run       = r_run - RunW'(1);
            n_out       = '{pcm_sample: pcm_of(r_sample),
                            run_last: (r_run == RunW'(1))};
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample    <= '0;
            r_pending   <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_sample    <= n_sample;
            r_pending   <= n_pending;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### src/run_coded_dpcm_audio_decoder.sv
// Top level of the run-coded DPCM audio decoder.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes one coded byte
// per request, with a flag for the raw start sample. Output channel
// (o_out_valid / i_out_ready / o_out_data) delivers 16-bit PCM samples;
// run_last marks the last sample a byte produced.
// A start byte, a literal byte and the first sample of a delta byte or a
// repeat run are written into the output register when the byte is
// taken. A delta byte yields its second sample from the DELTA2 state once
// the output register is free; a delta announcement gives no sample. The
// rest of a repeat run comes from the REPEAT state, one sample per cycle
// while the receiver does not stall.
// A new byte is taken while a finished sample still waits in the output
// register as long as that register is taken in the same cycle.
// When the receiver stalls, the output register holds and the controller
// waits; no sample is dropped. Reset (i_rst_n low, synchronous) clears the
// sample, the pending delta count and the run counter, and empties the
// output register.
module run_coded_dpcm_audio_decoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  rcdad_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output rcdad_pkg::t_out_item o_out_data
);
    import rcdad_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    rcdad_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    rcdad_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### test/rcdad_sample_checker.sv
// Scoreboard for the run-coded DPCM audio decoder: predicts PCM samples and checks them.
`timescale 1ns / 100ps

module rcdad_sample_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_ready,
    input  rcdad_pkg::t_in_item  i_in_data,
    input  logic                 i_out_valid,
    input  logic                 i_out_ready,
    input  rcdad_pkg::t_out_item i_out_data,
    output int                   o_fail_count,
    output int                   o_open_count,
    output int                   o_checked_count
);
    import rcdad_pkg::*;

    // Decoder state as the predictor sees it
    logic [7:0] level;
    logic [6:0] deltas_left;
    logic [7:0] held_ctl;

    t_out_item pcm_due[$];

    // (level - 64) * 256 on a signed 8-bit level, low 16 bits kept
    function automatic logic [15:0] level_to_pcm(input logic [7:0] s);
        logic signed [7:0] sv;
        int v;
        sv = s;
        v = (int'(sv) - 64) * 256;
        return v[15:0];
    endfunction

    function automatic logic [15:0] seed_to_pcm(input logic [7:0] s);
        logic signed [7:0] sv;
        int v;
        sv = s;
        v = int'(sv) * 256;
        return v[15:0];
    endfunction

    task automatic push_due(input logic [15:0] pcm, input logic last);
        t_out_item e;
        e.pcm_sample = pcm;
        e.run_last   = last;
        pcm_due.push_back(e);
    endtask

    task automatic decode_code(input t_in_item it);
        logic [7:0] b;
        logic [7:0] s1;
        logic [7:0] s2;
        logic signed [3:0] hi_step;
        logic signed [3:0] lo_step;
        int n;
        b = it.code_byte;
        hi_step = b[7:4];
        lo_step = b[3:0];
        if (it.stream_start) begin
            level       = b;
            deltas_left = '0;
            push_due(seed_to_pcm(b), 1'b1);
        end else if (deltas_left != 0) begin
            // high nibble first, each step wraps in 8 bits
            s1 = 8'(int'(level) + int'(hi_step));
            s2 = 8'(int'(s1) + int'(lo_step));
            push_due(level_to_pcm(s1), 1'b0);
            push_due(level_to_pcm(s2), 1'b1);
            level       = s2;
            deltas_left = deltas_left - 7'd1;
        end else begin
            held_ctl = b;
            if (!b[7]) begin
                level = b;
                push_due(level_to_pcm(b), 1'b1);
            end else if (b[7:6] == CtlDelta) begin
                deltas_left = 7'(b[5:0]) + 7'd1;
            end else begin
                n = int'(b[5:0]) + 1;
                for (int i = 0; i < n; i++) begin
                    push_due(level_to_pcm(level), i == n - 1);
                end
            end
        end
    endtask

    task automatic check_sample(input t_out_item got);
        t_out_item want;
        logic bad;
        o_checked_count++;
        if (pcm_due.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 40) begin
                $display("%0t: unexpected sample pcm=%0d last=%0b", $time,
                         got.pcm_sample, got.run_last);
            end
        end else begin
            want = pcm_due.pop_front();
            bad  = 1'b0;
            if (got.pcm_sample !== want.pcm_sample) bad = 1'b1;
            if (got.run_last !== want.run_last) bad = 1'b1;
            if (bad) begin
                o_fail_count++;
                if (o_fail_count <= 40) begin
                    $display("%0t: expected pcm=%0d last=%0b, got pcm=%0d last=%0b",
                             $time, want.pcm_sample, want.run_last,
                             got.pcm_sample, got.run_last);
                end
            end
        end
    endtask

    initial begin
        o_fail_count    = 0;
        o_open_count    = 0;
        o_checked_count = 0;
        level           = '0;
        deltas_left     = '0;
        held_ctl        = '0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            level       = '0;
            deltas_left = '0;
            held_ctl    = '0;
            pcm_due.delete();
        end else begin
            // a sample leaving now never comes from a byte taken at this edge
            if (i_out_valid && i_out_ready) check_sample(i_out_data);
            if (i_in_valid && i_in_ready) decode_code(i_in_data);
        end
        o_open_count = pcm_due.size();
    end

endmodule

### test/tb_run_coded_dpcm_audio_decoder.sv
// Testbench top for the run-coded DPCM audio decoder: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_run_coded_dpcm_audio_decoder;
    import rcdad_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;

    int fail_count;
    int open_count;
    int checked_count;

    bit calm;
    int hold_left;
    int items_sent;
    int n_starts;
    int n_literals;
    int n_repeats;
    int n_packets;

    run_coded_dpcm_audio_decoder dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data)
    );

    rcdad_sample_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .o_fail_count   (fail_count),
        .o_open_count   (open_count),
        .o_checked_count(checked_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return $urandom_range(0, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(9, 30);
    endfunction

    // receiver stalls
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            hold_left = pick_gap();
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    task automatic push_code(input logic [7:0] b, input logic st);
        int idle;
        idle = calm ? 0 : pick_gap();
        @(negedge clk);
        if (idle > 0) begin
            in_valid <= 1'b0;
            repeat (idle) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{code_byte: b, stream_start: st};
        do @(posedge clk); while (!in_ready);
        items_sent++;
    endtask

    task automatic push_start(input logic [7:0] b);
        n_starts++;
        push_code(b, 1'b1);
    endtask

    task automatic push_literal(input logic [6:0] v);
        n_literals++;
        push_code({1'b0, v}, 1'b0);
    endtask

    task automatic push_repeat(input logic [5:0] len_m1);
        n_repeats++;
        push_code({CtlRepeat, len_m1}, 1'b0);
    endtask

    task automatic push_announce(input logic [5:0] cnt_m1);
        n_packets++;
        push_code({CtlDelta, cnt_m1}, 1'b0);
    endtask

    function automatic logic [5:0] pick_run();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 6'($urandom_range(0, 7));
        if (r < 93) return 6'($urandom_range(8, 62));
        return 6'h3F;
    endfunction

    task automatic random_packet();
        int r;
        int cnt;
        logic [5:0] cnt_m1;
        r = $urandom_range(0, 99);
        if (r < 75) cnt_m1 = 6'($urandom_range(0, 5));
        else if (r < 96) cnt_m1 = 6'($urandom_range(6, 30));
        else cnt_m1 = 6'h3F;
        push_announce(cnt_m1);
        cnt = int'(cnt_m1) + 1;
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                // break the packet with a fresh seed
                push_start(8'($urandom_range(0, 255)));
                break;
            end else if (r < 7) begin
                // cut short: leftover deltas swallow what follows
                break;
            end
            push_code(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    initial begin
        int r;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_ready  = 1'b0;
        calm       = 1'b0;
        hold_left  = 0;
        items_sent = 0;
        n_starts   = 0;
        n_literals = 0;
        n_repeats  = 0;
        n_packets  = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // directed: field extremes, every kind of byte, the corner cases
        push_start(8'h00);
        push_start(8'h7F);
        push_start(8'h80);
        push_start(8'hFF);
        push_literal(7'h00);
        push_literal(7'h7F);
        push_literal(7'h40);
        push_repeat(6'h00);
        push_repeat(6'h3F);
        push_announce(6'd1);
        push_code(8'h7F, 1'b0);
        push_code(8'h88, 1'b0);
        // a delta byte that looks like a repeat control
        push_announce(6'd0);
        push_code(8'hC5, 1'b0);
        // start byte in the middle of a packet drops the pending deltas
        push_announce(6'h3F);
        push_code(8'h00, 1'b0);
        push_start(8'h10);
        push_literal(7'h3F);
        push_announce(6'd1);
        push_code(8'hF1, 1'b0);
        push_code(8'h0F, 1'b0);
        // most negative level: output wraps
        push_start(8'h80);
        push_repeat(6'd2);
        push_literal(7'h01);
        push_code(8'hFF, 1'b0);

        while (items_sent < 420) begin
            if (items_sent % 60 < 2) calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 8) push_start(8'($urandom_range(0, 255)));
            else if (r < 25) push_literal(7'($urandom_range(0, 127)));
            else if (r < 45) push_repeat(pick_run());
            else if (r < 90) random_packet();
            else push_code(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid <= 1'b0;
        while (open_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("Sent %0d code bytes: %0d seeds, %0d literals, %0d repeat runs, %0d packets.",
                 items_sent, n_starts, n_literals, n_repeats, n_packets);
        $display("Checked %0d PCM samples, %0d failures.", checked_count, fail_count);
        if (fail_count == 0 && open_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d samples still due.", open_count);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
